>>> rtl/rlwq_pkg.sv
// Shared types and constants for the recursive lock with wait queue.
`default_nettype none
package rlwq_pkg;

	localparam int THREAD_COUNT = 16;
	localparam int ID_W = 4;
	localparam int DEPTH_W = 8;
	localparam int ERR_W = 2;
	localparam int S_TDATA_W = 8;
	localparam int RES_W = 3 + ID_W + ERR_W + DEPTH_W;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

	localparam logic MODE_ACQUIRE = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NOT_OWNER = 2'd1;
	localparam logic [ERR_W-1:0] ERR_DUP_WAIT  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_DEPTH_SAT = 2'd3;

	typedef struct packed {
		logic            push;
		logic            pop;
		logic [ID_W-1:0] id;
	} q_ctl_t;

	typedef struct packed {
		logic            head_valid;
		logic [ID_W-1:0] head_id;
		logic            full;
	} q_stat_t;

endpackage
`default_nettype wire

>>> rtl/rlwq_cell.sv
// One slot of the wait queue: shifts towards the head on pop, loads on push.
`default_nettype none
module rlwq_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rlwq_pkg::q_ctl_t         ctl,
	input  wire logic                     prev_valid,
	input  wire logic                     next_valid,
	input  wire logic [rlwq_pkg::ID_W-1:0] next_id,
	output logic                          valid_q,
	output logic [rlwq_pkg::ID_W-1:0]     id_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (ctl.push && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			id_q <= next_id;
		end else if (ctl.push && !valid_q && prev_valid) begin
			id_q <= ctl.id;
		end
	end

endmodule
`default_nettype wire

>>> rtl/rlwq_queue.sv
// FIFO of waiting thread ids built as a row of shifting cells, head at cell 0.
`default_nettype none
module rlwq_queue #(
	parameter int DEPTH = rlwq_pkg::THREAD_COUNT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rlwq_pkg::q_ctl_t  ctl,
	output rlwq_pkg::q_stat_t      stat
);

	logic [DEPTH-1:0]              valid;
	logic [rlwq_pkg::ID_W-1:0]     ids [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      prev_v;
		logic                      next_v;
		logic [rlwq_pkg::ID_W-1:0] next_i;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_i = '0;
		end else begin : g_inner
			assign next_v = valid[i+1];
			assign next_i = ids[i+1];
		end

		rlwq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_id    (next_i),
			.valid_q    (valid[i]),
			.id_q       (ids[i])
		);
	end

	assign stat.head_valid = valid[0];
	assign stat.head_id    = ids[0];
	assign stat.full       = valid[DEPTH-1];

endmodule
`default_nettype wire

>>> rtl/recursive_lock_with_wait_queue.sv
// Recursive lock with FIFO wait queue: owner, depth and waiter tracking.
// The result item is registered and appears in the cycle after its request item is accepted.
// Throughput: one item per cycle while m_tready is high; the result register frees as it is taken.
// Lock state updates in the same edge that accepts the item.
// Reset (arst_n low, asynchronous) frees the lock and empties the queue.
`default_nettype none
module recursive_lock_with_wait_queue #(
	parameter int THREAD_COUNT = rlwq_pkg::THREAD_COUNT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [rlwq_pkg::S_TDATA_W-1:0]    s_tdata,  // thread_id
	input  wire logic                              s_tuser,  // mode
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// granted, blocked, woken_valid, woken_id, error_code, hold_depth
	output logic [rlwq_pkg::M_TDATA_W-1:0]         m_tdata
);

	localparam int MAP_W = 2 ** rlwq_pkg::ID_W;

	logic                             free_q;
	logic [rlwq_pkg::ID_W-1:0]        owner_q;
	logic [rlwq_pkg::DEPTH_W-1:0]     depth_q;
	logic [MAP_W-1:0]                 wait_map_q;
	logic                             out_valid_q;
	logic [rlwq_pkg::RES_W-1:0]       out_data_q;

	logic                             free_nxt;
	logic [rlwq_pkg::ID_W-1:0]        owner_nxt;
	logic [rlwq_pkg::DEPTH_W-1:0]     depth_nxt;
	logic [MAP_W-1:0]                 wait_map_nxt;
	logic                             granted;
	logic                             blocked;
	logic                             woken_valid;
	logic [rlwq_pkg::ID_W-1:0]        woken_id;
	logic [rlwq_pkg::ERR_W-1:0]       error_code;
	logic                             push;
	logic                             pop;

	logic                             accept;
	logic                             mode;
	logic [rlwq_pkg::ID_W-1:0]        tid;
	logic                             holds;
	rlwq_pkg::q_ctl_t                 q_ctl;
	rlwq_pkg::q_stat_t                q_st;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign mode     = s_tuser;
	assign tid      = s_tdata[rlwq_pkg::ID_W-1:0];
	assign holds    = !free_q && (owner_q == tid);

	always_comb begin
		free_nxt     = free_q;
		owner_nxt    = owner_q;
		depth_nxt    = depth_q;
		wait_map_nxt = wait_map_q;
		granted      = 1'b0;
		blocked      = 1'b0;
		woken_valid  = 1'b0;
		woken_id     = '0;
		error_code   = rlwq_pkg::ERR_OK;
		push         = 1'b0;
		pop          = 1'b0;
		if (mode == rlwq_pkg::MODE_ACQUIRE) begin
			if (holds) begin
				granted = 1'b1;
				if (depth_q == rlwq_pkg::DEPTH_MAX) begin
					error_code = rlwq_pkg::ERR_DEPTH_SAT;
				end else begin
					depth_nxt = depth_q + rlwq_pkg::DEPTH_ONE;
				end
			end else if (free_q) begin
				free_nxt  = 1'b0;
				owner_nxt = tid;
				depth_nxt = rlwq_pkg::DEPTH_ONE;
				granted   = 1'b1;
			end else if (wait_map_q[tid] || q_st.full) begin
				error_code = rlwq_pkg::ERR_DUP_WAIT;
			end else begin
				push              = 1'b1;
				wait_map_nxt[tid] = 1'b1;
				blocked           = 1'b1;
			end
		end else begin
			if (!holds) begin
				error_code = rlwq_pkg::ERR_NOT_OWNER;
			end else if (depth_q > rlwq_pkg::DEPTH_ONE) begin
				depth_nxt = depth_q - rlwq_pkg::DEPTH_ONE;
				granted   = 1'b1;
			end else if (q_st.head_valid) begin
				pop                       = 1'b1;
				woken_valid               = 1'b1;
				woken_id                  = q_st.head_id;
				wait_map_nxt[q_st.head_id] = 1'b0;
				owner_nxt                 = q_st.head_id;
				depth_nxt                 = rlwq_pkg::DEPTH_ONE;
			end else begin
				free_nxt  = 1'b1;
				owner_nxt = '0;
				depth_nxt = '0;
			end
		end
	end

	assign q_ctl.push = accept && push;
	assign q_ctl.pop  = accept && pop;
	assign q_ctl.id   = tid;

	rlwq_queue #(
		.DEPTH (THREAD_COUNT)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.stat   (q_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= 1'b1;
			owner_q     <= '0;
			depth_q     <= '0;
			wait_map_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				free_q     <= free_nxt;
				owner_q    <= owner_nxt;
				depth_q    <= depth_nxt;
				wait_map_q <= wait_map_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {depth_nxt, error_code, woken_id, woken_valid, blocked, granted};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(rlwq_pkg::M_TDATA_W - rlwq_pkg::RES_W){1'b0}}, out_data_q};

	// free lock carries no depth, held lock always at least one
	a_free_depth : assert property (@(posedge clk) disable iff (!arst_n)
		free_q |-> (depth_q == '0)) else $error("free lock with nonzero depth");
	a_held_depth : assert property (@(posedge clk) disable iff (!arst_n)
		!free_q |-> (depth_q != '0)) else $error("held lock with zero depth");
	// never free while anyone waits
	a_no_idle_waiters : assert property (@(posedge clk) disable iff (!arst_n)
		q_st.head_valid |-> !free_q) else $error("waiters queued on a free lock");
	// map and queue agree on emptiness
	a_map_queue : assert property (@(posedge clk) disable iff (!arst_n)
		(wait_map_q == '0) == !q_st.head_valid) else $error("wait map and queue disagree");
	// holder is never among the waiters
	a_owner_not_waiting : assert property (@(posedge clk) disable iff (!arst_n)
		!free_q |-> !wait_map_q[owner_q]) else $error("holder also queued");

endmodule
`default_nettype wire
